FILE: src/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared constants and round functions for the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds = 64;

    localparam logic [0:0] REQ_ABSORB = 1'b0;
    localparam logic [0:0] REQ_FINISH = 1'b1;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef logic [31:0] word_t;

    // request from the front end to the compression engine
    typedef struct packed {
        logic start;
    } comp_req_t;

    function automatic word_t rotr(input word_t v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: src/sha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ram
// generic single-port write, single-port registered read ram
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [0:Depth-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/sha_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_comp
// one-round-per-cycle compression engine, schedule kept in a 16-word window
// ----------------------------------------------------------------------------
module sha_comp (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::comp_req_t  req,
    output logic                busy,
    output logic                done,
    // block word fetch from the front end ram (registered read)
    output logic [3:0]          blk_addr,
    input  sha_pkg::word_t      blk_data,
    // hash word ram access
    output logic                h_wr_en,
    output logic [2:0]          h_wr_addr,
    output sha_pkg::word_t      h_wr_data,
    output logic [2:0]          h_rd_addr,
    input  sha_pkg::word_t      h_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_ADD, S_RESET
    } state_t;

    state_t              state_reg, state_next;
    logic [6:0]          cnt_reg, cnt_next;
    sha_pkg::word_t      w_reg [0:15];
    sha_pkg::word_t      s_reg [0:7];
    sha_pkg::word_t      t1, t2, wi, e, a, w_new;
    logic                done_reg, done_next;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // schedule: w[i] is w_reg[i] for i<16 as loaded; past that computed
    assign w_new = w_reg[0] + sha_pkg::sig0(w_reg[1]) + w_reg[9] + sha_pkg::sig1(w_reg[14]);
    assign wi = (cnt_reg < 7'd16) ? w_reg[cnt_reg[3:0]] : w_new;
    assign e = s_reg[4];
    assign a = s_reg[0];
    assign t1 = s_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
              + ((e & s_reg[5]) ^ (~e & s_reg[6])) + sha_pkg::ROUND_K[cnt_reg[5:0]] + wi;
    assign t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
              + ((a & s_reg[1]) ^ (a & s_reg[2]) ^ (s_reg[1] & s_reg[2]));

    // addresses: load phase reads block word cnt and hash word cnt (0..7)
    assign blk_addr  = cnt_reg[3:0];
    assign h_rd_addr = cnt_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        h_wr_en    = 1'b0;
        h_wr_addr  = cnt_reg[2:0];
        h_wr_data  = sha_pkg::INIT_H[cnt_reg[2:0]];
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    state_next = S_LOAD;
                    cnt_next   = 7'd0;
                end
            end
            S_LOAD:
            begin
                // address issued at cnt; the ram registers the read and the data is stored at index cnt-1
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16)
                begin
                    state_next = S_ROUND;
                    cnt_next   = 7'd0;
                end
            end
            S_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = S_ADD;
                    cnt_next   = 7'd0;
                end
            end
            S_ADD:
            begin
                // hash words are still held in w-independent copy: h_rd issued at cnt and
                // registered by the ram, add lands at cnt-1
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0)
                begin
                    h_wr_en   = 1'b1;
                    h_wr_addr = 3'(cnt_reg - 7'd1);
                    h_wr_data = h_rd_data + s_reg[3'(cnt_reg - 7'd1)];
                end
                if (cnt_reg == 7'd8)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    cnt_next   = 7'd0;
                end
            end
            S_RESET:
            begin
                h_wr_en  = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd7)
                begin
                    state_next = S_IDLE;
                    cnt_next   = 7'd0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RESET;
            cnt_reg   <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && cnt_reg != 7'd0)
        begin
            w_reg[4'(cnt_reg - 7'd1)] <= blk_data;
            if (cnt_reg <= 7'd8)
            begin
                s_reg[3'(cnt_reg - 7'd1)] <= h_rd_data;
            end
        end
        else if (state_reg == S_ROUND)
        begin
            if (cnt_reg >= 7'd16)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= w_new;
            end
            else if (cnt_reg == 7'd15)
            begin
                // window already holds w0..w15 in order
            end
            s_reg[7] <= s_reg[6];
            s_reg[6] <= s_reg[5];
            s_reg[5] <= s_reg[4];
            s_reg[4] <= s_reg[3] + t1;
            s_reg[3] <= s_reg[2];
            s_reg[2] <= s_reg[1];
            s_reg[1] <= s_reg[0];
            s_reg[0] <= t1 + t2;
        end
    end

    property p_done_from_add;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(state_reg == S_ADD);
    endproperty
    a_done_from_add: assert property (p_done_from_add) else $error("done without add phase");

    property p_round_cnt;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_ROUND) |-> (cnt_reg < 7'd64);
    endproperty
    a_round_cnt: assert property (p_round_cnt) else $error("round counter overrun");

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n)
            (req.start && state_reg == S_IDLE) |=> (state_reg == S_LOAD);
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("start not taken");

endmodule

FILE: src/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// streaming sha-256: bytes in, eight digest words out per finish
// ----------------------------------------------------------------------------
// absorb: one byte per cycle; the 64th byte of a block starts a compression
//   (load, round and add phases), during which input stalls
// finish: padding writes up to 64 bytes into the block ram one per cycle, then
//   one or two compressions, then 8 output transactions, each a read, a
//   register and a handshake, then restoring the hash ram
// reset: asynchronous; the hash ram is loaded with initial values
module sha256_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last
);

    typedef enum logic [2:0] {
        F_IDLE, F_PAD, F_COMP, F_RINIT, F_OUT
    } fstate_t;

    fstate_t         state_reg, state_next;
    logic [5:0]      fill_reg, fill_next;     // bytes in block
    logic [60:0]     msg_reg, msg_next;
    logic [5:0]      pos_reg, pos_next;       // padding write pointer
    logic            two_reg, two_next;       // one more block follows
    logic            fin_reg, fin_next;       // compression is the last one of a finish
    logic [3:0]      oidx_reg, oidx_next;
    logic            ovalid_reg, ovalid_next;
    logic            rd_pend_reg, rd_pend_next;
    logic [3:0]      ri_reg, ri_next;

    // block ram byte lanes: four 8-bit rams, one per byte of a word
    logic [3:0]      lane_we;
    logic [3:0]      lane_waddr;
    logic [7:0]      lane_wdata;
    logic [3:0]      blk_addr;
    sha_pkg::word_t  blk_data;

    sha_pkg::comp_req_t creq;
    logic            c_busy, c_done;
    logic            h_wr_en_c, h_wr_en;
    logic [2:0]      h_wr_addr_c, h_wr_addr, h_rd_addr_c, h_rd_addr;
    sha_pkg::word_t  h_wr_data_c, h_wr_data, h_rd_data;

    logic            acc;
    logic [63:0]     bits;
    logic [7:0]      pad_byte;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            sha_ram #(.Width(8), .Depth(16)) u_lane (
                .clk     (clk),
                .wr_en   (lane_we[g]),
                .wr_addr (lane_waddr),
                .wr_data (lane_wdata),
                .rd_addr (blk_addr),
                .rd_data (blk_data[31 - 8*g -: 8])
            );
        end
    endgenerate

    sha_ram #(.Width(32), .Depth(8)) u_hash (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    sha_comp u_comp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (creq),
        .busy      (c_busy),
        .done      (c_done),
        .blk_addr  (blk_addr),
        .blk_data  (blk_data),
        .h_wr_en   (h_wr_en_c),
        .h_wr_addr (h_wr_addr_c),
        .h_wr_data (h_wr_data_c),
        .h_rd_addr (h_rd_addr_c),
        .h_rd_data (h_rd_data)
    );

    assign s_tready = (state_reg == F_IDLE) && !c_busy;
    assign acc      = s_tvalid && s_tready;
    assign bits     = {msg_reg, 3'b000};

    // padding byte at position pos_reg
    always_comb
    begin
        if (pos_reg >= 6'd56 && !two_reg)
        begin
            pad_byte = bits[8*(63 - pos_reg) +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // hash ram port shared: engine normally, reinit and output readout here
    always_comb
    begin
        h_wr_en   = h_wr_en_c;
        h_wr_addr = h_wr_addr_c;
        h_wr_data = h_wr_data_c;
        h_rd_addr = h_rd_addr_c;
        if (state_reg == F_OUT)
        begin
            h_rd_addr = oidx_reg[2:0];
        end
        else if (state_reg == F_RINIT)
        begin
            h_wr_en   = 1'b1;
            h_wr_addr = ri_reg[2:0];
            h_wr_data = sha_pkg::INIT_H[ri_reg[2:0]];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        msg_next     = msg_reg;
        pos_next     = pos_reg;
        two_next     = two_reg;
        fin_next     = fin_reg;
        oidx_next    = oidx_reg;
        ovalid_next  = ovalid_reg;
        rd_pend_next = rd_pend_reg;
        ri_next      = ri_reg;
        lane_we      = 4'b0000;
        lane_waddr   = fill_reg[5:2];
        lane_wdata   = s_tdata;
        creq         = '0;
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            F_IDLE:
            begin
                if (acc && s_tuser == sha_pkg::REQ_ABSORB)
                begin
                    lane_we[fill_reg[1:0]] = 1'b1;
                    msg_next  = msg_reg + 61'd1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        creq.start = 1'b1;
                        fin_next   = 1'b0;
                    end
                end
                else if (acc)
                begin
                    // place 0x80, padding continues from the next byte
                    lane_we[fill_reg[1:0]] = 1'b1;
                    lane_wdata = 8'h80;
                    two_next   = (fill_reg >= 6'd56);
                    pos_next   = fill_reg + 6'd1;
                    state_next = (fill_reg == 6'd63) ? F_COMP : F_PAD;
                    if (fill_reg == 6'd63)
                    begin
                        creq.start = 1'b1;
                        fin_next   = 1'b0;
                    end
                end
            end
            F_PAD:
            begin
                lane_we[pos_reg[1:0]] = 1'b1;
                lane_waddr = pos_reg[5:2];
                lane_wdata = pad_byte;
                pos_next   = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    creq.start = 1'b1;
                    fin_next   = !two_reg;
                    state_next = F_COMP;
                end
            end
            F_COMP:
            begin
                if (c_done)
                begin
                    if (fin_reg)
                    begin
                        state_next   = F_OUT;
                        oidx_next    = 4'd0;
                        rd_pend_next = 1'b0;
                    end
                    else
                    begin
                        // second block: all zeros then length
                        two_next   = 1'b0;
                        pos_next   = 6'd0;
                        state_next = F_PAD;
                    end
                end
            end
            F_OUT:
            begin
                // read issued at oidx, registered read data captured into output reg on rd_pend
                if (!rd_pend_reg && !ovalid_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else if (rd_pend_reg)
                begin
                    rd_pend_next = 1'b0;
                    ovalid_next  = 1'b1;
                end
                else if (ovalid_reg && m_tready)
                begin
                    oidx_next = oidx_reg + 4'd1;
                    if (oidx_reg == 4'd7)
                    begin
                        state_next = F_RINIT;
                        ri_next    = 4'd0;
                    end
                end
            end
            F_RINIT:
            begin
                ri_next = ri_reg + 4'd1;
                if (ri_reg == 4'd7)
                begin
                    state_next = F_IDLE;
                    fill_next  = 6'd0;
                    msg_next   = '0;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            fill_reg    <= 6'd0;
            msg_reg     <= '0;
            pos_reg     <= 6'd0;
            two_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            oidx_reg    <= 4'd0;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            ri_reg      <= 4'd0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            msg_reg     <= msg_next;
            pos_reg     <= pos_next;
            two_reg     <= two_next;
            fin_reg     <= fin_next;
            oidx_reg    <= oidx_next;
            ovalid_reg  <= ovalid_next;
            rd_pend_reg <= rd_pend_next;
            ri_reg      <= ri_next;
        end
    end

    // output payload register
    logic [31:0] oword_reg;
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            oword_reg <= h_rd_data;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, oidx_reg[2:0], oword_reg};
    assign m_tlast  = (oidx_reg == 4'd7);

    property p_no_input_when_busy;
        @(posedge clk) disable iff (!rst_n) c_busy |-> !s_tready;
    endproperty
    a_no_input_when_busy: assert property (p_no_input_when_busy)
        else $error("input taken during compression");

    property p_out_only_in_out;
        @(posedge clk) disable iff (!rst_n) ovalid_reg |-> (state_reg == F_OUT);
    endproperty
    a_out_only_in_out: assert property (p_out_only_in_out)
        else $error("digest word outside readout");

    property p_last_ends;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && m_tready && m_tlast) |=> (state_reg == F_RINIT);
    endproperty
    a_last_ends: assert property (p_last_ends) else $error("readout did not finish");

endmodule
